/* rtl/core/mpa_pkg.sv */
// Shared types, constants and helpers for the max pooling block.
package mpa_pkg;

    // Defaults for the size parameters of the top level.
    localparam int MAX_KERNEL_DEF   = 8;
    localparam int MAX_ROWS_DEF     = 256;
    localparam int MAX_COLS_DEF     = 128;
    localparam int MAX_CHANNELS_DEF = 32;
    localparam int MAX_IMAGES_DEF   = 16;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_KERNEL_ROWS   = 3'd0;
    localparam logic [2:0] REG_KERNEL_COLS   = 3'd1;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd2;
    localparam logic [2:0] REG_MAP_ROWS      = 3'd3;
    localparam logic [2:0] REG_MAP_COLS      = 3'd4;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd5;
    localparam logic [2:0] REG_IMAGE_COUNT   = 3'd6;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Configuration register set.
    typedef struct packed {
        logic [3:0] kernel_rows;
        logic [3:0] kernel_cols;
        logic [7:0] step_size;
        logic [8:0] map_rows;
        logic [7:0] map_cols;
        logic [5:0] channel_count;
        logic [4:0] image_count;
    } mpa_cfg_t;

    // Bits needed to index a range of n entries, at least one.
    function automatic int idx_bits(input int n);
        int b;
        b = $clog2(n);
        return (b < 1) ? 1 : b;
    endfunction

endpackage

/* rtl/core/max_pool_2d_with_argmax.sv */
// Top level of the 2-D max pooling block with argmax over an NHWC stream.
//
// Samples enter on the s_ channel in image, row, column, channel order and
// are written to a line store that holds the last MAX_KERNEL map rows.
// A sample that closes a pooling window starts a scan of that window: one
// line store read per cycle, row-major, followed by a drain state and
// three multiply steps for the flat index; no new item is accepted until
// the block returns to idle. The scan is serial because of the single
// read port of the line store.
// Results leave on the m_ channel through an output register, so a new
// item is accepted while a result waits; a stalled receiver only holds
// the block when the next result is ready to be written.
// Reset restores the default registers and sets the stream position to
// the start of a batch; the line store is not cleared, since a window only
// reads entries written earlier in the same image. A write to an existing
// register also restarts the stream. With an invalid configuration items are consumed
// and no result is produced.
module max_pool_2d_with_argmax #(
    parameter int MAX_KERNEL   = mpa_pkg::MAX_KERNEL_DEF,
    parameter int MAX_ROWS     = mpa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = mpa_pkg::MAX_COLS_DEF,
    parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_IMAGES   = mpa_pkg::MAX_IMAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpa_pkg::ADDR_W-1:0]  paddr,
    input  logic [mpa_pkg::DATA_W-1:0]  pwdata,
    output logic [mpa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_max_value,
    output logic [23:0]                 m_max_index,
    output logic                        m_final_output
);

    localparam int DEPTH = MAX_KERNEL * MAX_COLS * MAX_CHANNELS;
    localparam int AW    = mpa_pkg::idx_bits(DEPTH);
    localparam int KW    = mpa_pkg::idx_bits(MAX_KERNEL);
    localparam int RW    = mpa_pkg::idx_bits(MAX_ROWS);
    localparam int CW    = mpa_pkg::idx_bits(MAX_COLS);
    localparam int HW    = mpa_pkg::idx_bits(MAX_CHANNELS);
    localparam int IW    = mpa_pkg::idx_bits(MAX_IMAGES);
    localparam int OW    = mpa_pkg::idx_bits(MAX_ROWS + MAX_COLS + 256) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_IDX1  = 3'd3;
    localparam logic [2:0] ST_IDX2  = 3'd4;
    localparam logic [2:0] ST_IDX3  = 3'd5;

    mpa_pkg::mpa_cfg_t cfg;
    logic              cfg_ok;
    logic              restart;

    mpa_regs #(
        .MAX_KERNEL(MAX_KERNEL), .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGES(MAX_IMAGES)
    ) u_regs (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg), .cfg_ok(cfg_ok), .restart(restart)
    );

    logic [2:0]    state_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [HW-1:0] chan_reg;
    logic [IW-1:0] img_reg;
    logic [KW-1:0] slot_reg;
    logic [OW-1:0] oy_reg;
    logic [OW-1:0] ox_reg;

    // Captured window context.
    logic [RW-1:0] sy_reg;
    logic [CW-1:0] sx_reg;
    logic [HW-1:0] wch_reg;
    logic [IW-1:0] wimg_reg;
    logic          wlast_reg;
    logic [KW-1:0] rslot_reg;
    logic [3:0]    ky_reg;
    logic [3:0]    kx_reg;

    // Read-return tags and running maximum.
    logic          rvalid_reg;
    logic          first_reg;
    logic [3:0]    tky_reg;
    logic [3:0]    tkx_reg;
    logic signed [15:0] best_reg;
    logic [3:0]    bky_reg;
    logic [3:0]    bkx_reg;
    logic [23:0]   idx_reg;

    logic          m_valid_reg;
    logic signed [15:0] m_value_reg;
    logic [23:0]   m_index_reg;
    logic          m_final_reg;

    logic          accept;
    logic          closes;
    logic          chan_last;
    logic          col_last;
    logic          row_last;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [15:0]   rd_data;
    logic [KW-1:0] base_slot;
    logic          out_free;
    int            base_tmp;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign chan_last = (int'(chan_reg) + 1 >= int'(cfg.channel_count));
    assign col_last  = (int'(col_reg) + 1 >= int'(cfg.map_cols));
    assign row_last  = (int'(row_reg) + 1 >= int'(cfg.map_rows));
    assign closes    = (int'(row_reg) == int'(oy_reg) + int'(cfg.kernel_rows) - 1) &&
                       (int'(col_reg) == int'(ox_reg) + int'(cfg.kernel_cols) - 1);

    // Store slot of the window's top row.
    always_comb begin
        base_tmp = int'(slot_reg) - int'(cfg.kernel_rows) + 1;
        if (base_tmp < 0) base_tmp = base_tmp + MAX_KERNEL;
        base_slot = KW'(base_tmp);
    end

    assign wr_addr = AW'((int'(slot_reg) * MAX_COLS + int'(col_reg)) * MAX_CHANNELS
                         + int'(chan_reg));
    assign rd_addr = AW'((int'(rslot_reg) * MAX_COLS + int'(sx_reg) + int'(kx_reg))
                         * MAX_CHANNELS + int'(wch_reg));
    assign rd_en   = (state_reg == ST_READ);

    mpa_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .aclk(aclk), .wr_en(accept && cfg_ok), .wr_addr(wr_addr), .wr_data(s_sample),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Stream position and window origin tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
            img_reg  <= '0;
            slot_reg <= '0;
            oy_reg   <= '0;
            ox_reg   <= '0;
        end else if (accept && cfg_ok) begin
            if (chan_last) begin
                chan_reg <= '0;
                if (col_last) begin
                    col_reg <= '0;
                    ox_reg  <= '0;
                    if (row_last) begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                        oy_reg   <= '0;
                        img_reg  <= (int'(img_reg) + 1 >= int'(cfg.image_count)) ?
                                    '0 : IW'(int'(img_reg) + 1);
                    end else begin
                        row_reg  <= RW'(int'(row_reg) + 1);
                        slot_reg <= (int'(slot_reg) == MAX_KERNEL - 1) ?
                                    '0 : KW'(int'(slot_reg) + 1);
                        if (int'(row_reg) == int'(oy_reg) + int'(cfg.kernel_rows) - 1)
                            oy_reg <= OW'(int'(oy_reg) + int'(cfg.step_size));
                    end
                end else begin
                    col_reg <= CW'(int'(col_reg) + 1);
                    if (int'(col_reg) == int'(ox_reg) + int'(cfg.kernel_cols) - 1)
                        ox_reg <= OW'(int'(ox_reg) + int'(cfg.step_size));
                end
            end else begin
                chan_reg <= HW'(int'(chan_reg) + 1);
            end
        end
    end

    // Window scan sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= rd_en;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && cfg_ok && closes) state_reg <= ST_READ;
                end
                ST_READ: begin
                    if (kx_reg + 4'd1 == cfg.kernel_cols &&
                        ky_reg + 4'd1 == cfg.kernel_rows) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: state_reg <= ST_IDX1;
                ST_IDX1:  state_reg <= ST_IDX2;
                ST_IDX2:  state_reg <= ST_IDX3;
                ST_IDX3: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Window context capture and read counters.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            sy_reg    <= RW'(oy_reg);
            sx_reg    <= CW'(ox_reg);
            wch_reg   <= chan_reg;
            wimg_reg  <= img_reg;
            rslot_reg <= base_slot;
            ky_reg    <= '0;
            kx_reg    <= '0;
            first_reg <= 1'b1;
            wlast_reg <= (int'(img_reg) + 1 == int'(cfg.image_count)) &&
                         (int'(chan_reg) + 1 == int'(cfg.channel_count)) &&
                         (int'(oy_reg) + int'(cfg.step_size) >
                          int'(cfg.map_rows) - int'(cfg.kernel_rows)) &&
                         (int'(ox_reg) + int'(cfg.step_size) >
                          int'(cfg.map_cols) - int'(cfg.kernel_cols));
        end else if (state_reg == ST_READ) begin
            if (kx_reg + 4'd1 == cfg.kernel_cols) begin
                kx_reg    <= '0;
                ky_reg    <= ky_reg + 4'd1;
                rslot_reg <= (int'(rslot_reg) == MAX_KERNEL - 1) ?
                             '0 : KW'(int'(rslot_reg) + 1);
            end else begin
                kx_reg <= kx_reg + 4'd1;
            end
        end
        tky_reg <= ky_reg;
        tkx_reg <= kx_reg;
        // Running maximum; the strict test keeps the first maximum.
        if (rvalid_reg) begin
            first_reg <= 1'b0;
            if (first_reg || $signed(rd_data) > best_reg) begin
                best_reg <= $signed(rd_data);
                bky_reg  <= tky_reg;
                bkx_reg  <= tkx_reg;
            end
        end
        // Flat index, one multiply per step.
        if (state_reg == ST_IDX1) begin
            idx_reg <= 24'(32'(wimg_reg) * 32'(cfg.map_rows) + 32'(sy_reg) + 32'(bky_reg));
        end else if (state_reg == ST_IDX2) begin
            idx_reg <= 24'({8'd0, idx_reg} * 32'(cfg.map_cols) + 32'(sx_reg)
                           + 32'(bkx_reg));
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_IDX3 && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_IDX3 && out_free) begin
            m_value_reg <= best_reg;
            m_index_reg <= 24'({8'd0, idx_reg} * 32'(cfg.channel_count) + 32'(wch_reg));
            m_final_reg <= wlast_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_max_value    = m_value_reg;
    assign m_max_index    = m_index_reg;
    assign m_final_output = m_final_reg;

    // A consumed item under an invalid configuration never starts a scan.
    a_invalid_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_ok) |=> (state_reg == ST_IDLE))
        else $error("scan started under invalid configuration");

    // Read counters stay inside the window.
    a_scan_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (kx_reg < cfg.kernel_cols && ky_reg < cfg.kernel_rows))
        else $error("window read beyond kernel");

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !restart) |=> (m_valid && $stable(m_max_index)))
        else $error("pending result overwritten");

endmodule

/* rtl/core/mpa_regs.sv */
// Configuration registers with their APB-style write and read port.
module mpa_regs #(
    parameter int MAX_KERNEL   = mpa_pkg::MAX_KERNEL_DEF,
    parameter int MAX_ROWS     = mpa_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS     = mpa_pkg::MAX_COLS_DEF,
    parameter int MAX_CHANNELS = mpa_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_IMAGES   = mpa_pkg::MAX_IMAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpa_pkg::ADDR_W-1:0]  paddr,
    input  logic [mpa_pkg::DATA_W-1:0]  pwdata,
    output logic [mpa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mpa_pkg::mpa_cfg_t           cfg,
    output logic                        cfg_ok,
    output logic                        restart
);

    mpa_pkg::mpa_cfg_t cfg_reg;
    logic [2:0]        reg_index;
    logic              wr_fire;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_fire   = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register writes; any write to an existing register restarts the stream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kernel_rows   <= 4'd2;
            cfg_reg.kernel_cols   <= 4'd2;
            cfg_reg.step_size     <= 8'd2;
            cfg_reg.map_rows      <= 9'd256;
            cfg_reg.map_cols      <= 8'd128;
            cfg_reg.channel_count <= 6'd32;
            cfg_reg.image_count   <= 5'd1;
        end else if (wr_fire) begin
            unique case (reg_index)
                mpa_pkg::REG_KERNEL_ROWS:   cfg_reg.kernel_rows   <= pwdata[3:0];
                mpa_pkg::REG_KERNEL_COLS:   cfg_reg.kernel_cols   <= pwdata[3:0];
                mpa_pkg::REG_STEP_SIZE:     cfg_reg.step_size     <= pwdata[7:0];
                mpa_pkg::REG_MAP_ROWS:      cfg_reg.map_rows      <= pwdata[8:0];
                mpa_pkg::REG_MAP_COLS:      cfg_reg.map_cols      <= pwdata[7:0];
                mpa_pkg::REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[5:0];
                mpa_pkg::REG_IMAGE_COUNT:   cfg_reg.image_count   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    assign restart = wr_fire && (reg_index <= mpa_pkg::REG_IMAGE_COUNT);

    // Read mux.
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            mpa_pkg::REG_KERNEL_ROWS:   prdata = 32'(cfg_reg.kernel_rows);
            mpa_pkg::REG_KERNEL_COLS:   prdata = 32'(cfg_reg.kernel_cols);
            mpa_pkg::REG_STEP_SIZE:     prdata = 32'(cfg_reg.step_size);
            mpa_pkg::REG_MAP_ROWS:      prdata = 32'(cfg_reg.map_rows);
            mpa_pkg::REG_MAP_COLS:      prdata = 32'(cfg_reg.map_cols);
            mpa_pkg::REG_CHANNEL_COUNT: prdata = 32'(cfg_reg.channel_count);
            mpa_pkg::REG_IMAGE_COUNT:   prdata = 32'(cfg_reg.image_count);
            default:                    prdata = '0;
        endcase
    end

    // Validity check of the whole register set.
    always_comb begin
        cfg_ok = 1'b1;
        if (cfg_reg.kernel_rows < 4'd1 || int'(cfg_reg.kernel_rows) > MAX_KERNEL) cfg_ok = 1'b0;
        if (cfg_reg.kernel_cols < 4'd1 || int'(cfg_reg.kernel_cols) > MAX_KERNEL) cfg_ok = 1'b0;
        if (cfg_reg.step_size == 8'd0) cfg_ok = 1'b0;
        if (cfg_reg.map_rows == 9'd0 || int'(cfg_reg.map_rows) > MAX_ROWS) cfg_ok = 1'b0;
        if (cfg_reg.map_cols == 8'd0 || int'(cfg_reg.map_cols) > MAX_COLS) cfg_ok = 1'b0;
        if (cfg_reg.channel_count == 6'd0 || int'(cfg_reg.channel_count) > MAX_CHANNELS)
            cfg_ok = 1'b0;
        if (cfg_reg.image_count == 5'd0 || int'(cfg_reg.image_count) > MAX_IMAGES)
            cfg_ok = 1'b0;
        if (int'(cfg_reg.kernel_rows) > int'(cfg_reg.map_rows)) cfg_ok = 1'b0;
        if (int'(cfg_reg.kernel_cols) > int'(cfg_reg.map_cols)) cfg_ok = 1'b0;
    end

endmodule

/* rtl/core/mpa_store.sv */
// Line store: single-port-write, single-port-read synchronous memory.
module mpa_store #(
    parameter int DEPTH = 8 * 128 * 32,
    parameter int AW    = mpa_pkg::idx_bits(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
